FILE: src/wraparound_zone_crossing_table_macros.svh
// Assertion helpers shared by the zone crossing table RTL.
`ifndef WRAPAROUND_ZONE_CROSSING_TABLE_MACROS_SVH
`define WRAPAROUND_ZONE_CROSSING_TABLE_MACROS_SVH

// Property that must hold at every clock edge outside of reset.
`define WZCT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside of reset.
`define WZCT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

FILE: src/wzct_pkg.sv
package wzct_pkg;

    localparam int TABLE_DEPTH_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 15;
    localparam int POS_W             = 16;
    localparam int REGION_W          = 8;

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_REMOVE   = 2'd1,
        OP_EVALUATE = 2'd2,
        OP_CLEAR    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_ENTER = 2'd1,
        KIND_EXIT  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_INVALID = 2'd1,
        STATUS_FULL    = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CHK,
        ST_REM_RD,
        ST_REM_CHK,
        ST_EVL_RD,
        ST_EVL_CHK,
        ST_EVL_END,
        ST_ACK
    } t_state;

    typedef struct packed {
        logic [POS_W-1:0]    zstart;
        logic [POS_W-1:0]    zend;
        logic [REGION_W-1:0] region;
    } t_zone;

endpackage

FILE: src/wraparound_zone_crossing_table.sv
// Zone crossing table for a circular track. Zones are kept sorted by start in one
// synchronous zone memory (start, end, region id); positions are unsigned fixed point
// with 1.0 = 2**FRACTION_BITS, and an end above 1.0 wraps past the origin. One command
// is in work at a time; o_in_stall is high from the accepting edge until its last
// result has entered the output register, which may still be waiting on i_out_stall
// when the next command is taken. Every table step reads one entry and then uses its
// registered read data: insert reads down from the top until an entry whose start is
// not larger or the bottom, remove and evaluate read every stored zone, and clear and
// a rejected insert read none; any of them can wait on the output side. Evaluate
// returns one transfer per zone entered or exited, in table order, with o_last on the
// final one, or a single acknowledge.
`include "wraparound_zone_crossing_table_macros.svh"

module wraparound_zone_crossing_table #(
    parameter int TABLE_DEPTH   = wzct_pkg::TABLE_DEPTH_DEF,
    parameter int FRACTION_BITS = wzct_pkg::FRACTION_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_operation,
    input  logic [wzct_pkg::REGION_W-1:0] i_region_id,
    input  logic [wzct_pkg::POS_W-1:0]    i_range_start,
    input  logic [wzct_pkg::POS_W-1:0]    i_range_end,
    input  logic [wzct_pkg::POS_W-1:0]    i_prev_start,
    input  logic [wzct_pkg::POS_W-1:0]    i_prev_end,
    input  logic [wzct_pkg::POS_W-1:0]    i_cur_start,
    input  logic [wzct_pkg::POS_W-1:0]    i_cur_end,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_event_kind,
    output logic [wzct_pkg::REGION_W-1:0] o_event_region,
    output logic [1:0]                    o_status,
    output logic                          o_last
);

    localparam int PW = wzct_pkg::POS_W;
    localparam int RW = wzct_pkg::REGION_W;
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int WW = (FRACTION_BITS + 2 > PW + 1) ? FRACTION_BITS + 2 : PW + 1;
    localparam logic [WW-1:0] POS_ONE = {{(WW-1){1'b0}}, 1'b1} << FRACTION_BITS;
    localparam logic [WW-1:0] POS_TWO = POS_ONE << 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    // Wraparound overlap of a position span (s1, e1) with a zone (s2, e2).
    function automatic logic span_hits(input logic [WW-1:0] s1, input logic [WW-1:0] e1,
                                       input logic [WW-1:0] s2, input logic [WW-1:0] e2);
        logic hit;
        if (s1 < e2) begin
            hit = (e1 >= s2) || ((e2 > POS_ONE) && (s1 + POS_ONE <= e2));
        end else begin
            hit = (e1 > POS_ONE) && (s2 + POS_ONE <= e1);
        end
        return hit;
    endfunction

    wzct_pkg::t_zone r_mem [TABLE_DEPTH];
    wzct_pkg::t_zone r_rd_data;

    wzct_pkg::t_state  r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_wr, n_wr;
    wzct_pkg::t_status r_status, n_status;
    logic [RW-1:0]     r_region, n_region;
    logic [PW-1:0]     r_rs, n_rs;
    logic [PW-1:0]     r_re, n_re;
    logic [PW-1:0]     r_ps, n_ps;
    logic [PW-1:0]     r_pe, n_pe;
    logic [PW-1:0]     r_cs, n_cs;
    logic [PW-1:0]     r_ce, n_ce;
    logic              r_pend_valid, n_pend_valid;
    wzct_pkg::t_kind   r_pend_kind, n_pend_kind;
    logic [RW-1:0]     r_pend_region, n_pend_region;

    logic              r_out_valid;
    wzct_pkg::t_kind   r_out_kind;
    logic [RW-1:0]     r_out_region;
    wzct_pkg::t_status r_out_status;
    logic              r_out_last;

    logic              in_xfer;
    logic              can_push;
    logic              push;
    wzct_pkg::t_kind   push_kind;
    logic [RW-1:0]     push_region;
    wzct_pkg::t_status push_status;
    logic              push_last;

    logic              mem_re;
    logic [AW-1:0]     mem_rd_addr;
    logic              mem_we;
    logic [AW-1:0]     mem_wr_addr;
    wzct_pkg::t_zone   mem_wr_data;

    logic [PW-1:0]     end_clamped;
    logic              range_bad;
    logic              was_in;
    logic              now_in;
    wzct_pkg::t_zone   new_zone;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign can_push = !r_out_valid || !i_out_stall;

    assign end_clamped = (i_range_end < i_range_start) ? i_range_start : i_range_end;
    assign range_bad   = (WW'(i_range_start) > POS_ONE) || (WW'(end_clamped) > POS_TWO);

    assign was_in = span_hits(WW'(r_ps), WW'(r_pe), WW'(r_rd_data.zstart),
                              WW'(r_rd_data.zend));
    assign now_in = span_hits(WW'(r_cs), WW'(r_ce), WW'(r_rd_data.zstart),
                              WW'(r_rd_data.zend));

    assign new_zone = '{zstart: r_rs, zend: r_re, region: r_region};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= wzct_pkg::ST_IDLE;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_wr          <= n_wr;
        r_status      <= n_status;
        r_region      <= n_region;
        r_rs          <= n_rs;
        r_re          <= n_re;
        r_ps          <= n_ps;
        r_pe          <= n_pe;
        r_cs          <= n_cs;
        r_ce          <= n_ce;
        r_pend_kind   <= n_pend_kind;
        r_pend_region <= n_pend_region;
        if (push) begin
            r_out_kind   <= push_kind;
            r_out_region <= push_region;
            r_out_status <= push_status;
            r_out_last   <= push_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wr_addr] <= mem_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_data <= r_mem[mem_rd_addr];
        end
    end

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_idx         = r_idx;
        n_wr          = r_wr;
        n_status      = r_status;
        n_region      = r_region;
        n_rs          = r_rs;
        n_re          = r_re;
        n_ps          = r_ps;
        n_pe          = r_pe;
        n_cs          = r_cs;
        n_ce          = r_ce;
        n_pend_valid  = r_pend_valid;
        n_pend_kind   = r_pend_kind;
        n_pend_region = r_pend_region;
        push          = 1'b0;
        push_kind     = wzct_pkg::KIND_ACK;
        push_region   = '0;
        push_status   = wzct_pkg::STATUS_OK;
        push_last     = 1'b1;
        mem_re        = 1'b0;
        mem_rd_addr   = r_idx[AW-1:0];
        mem_we        = 1'b0;
        mem_wr_addr   = r_idx[AW-1:0];
        mem_wr_data   = new_zone;
        o_in_stall    = 1'b1;

        unique case (r_state)
            wzct_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (in_xfer) begin
                    n_region = i_region_id;
                    n_rs     = i_range_start;
                    n_re     = end_clamped;
                    n_ps     = i_prev_start;
                    n_pe     = (i_prev_end < i_prev_start) ? i_prev_start : i_prev_end;
                    n_cs     = i_cur_start;
                    n_ce     = (i_cur_end < i_cur_start) ? i_cur_start : i_cur_end;
                    n_status = wzct_pkg::STATUS_OK;
                    n_idx    = '0;
                    n_wr     = '0;
                    unique case (wzct_pkg::t_op'(i_operation))
                        wzct_pkg::OP_INSERT: begin
                            n_idx = r_count;
                            if (range_bad) begin
                                n_status = wzct_pkg::STATUS_INVALID;
                                n_state  = wzct_pkg::ST_ACK;
                            end else if (r_count >= DEPTH_C) begin
                                n_status = wzct_pkg::STATUS_FULL;
                                n_state  = wzct_pkg::ST_ACK;
                            end else begin
                                n_state = wzct_pkg::ST_INS_RD;
                            end
                        end
                        wzct_pkg::OP_REMOVE: begin
                            n_state = wzct_pkg::ST_REM_RD;
                        end
                        wzct_pkg::OP_EVALUATE: begin
                            n_pend_valid = 1'b0;
                            n_state      = wzct_pkg::ST_EVL_RD;
                        end
                        wzct_pkg::OP_CLEAR: begin
                            n_count = '0;
                            n_state = wzct_pkg::ST_ACK;
                        end
                    endcase
                end
            end

            // Insert walks down from the top of the table, moving each entry with a
            // larger start up by one, and drops the new zone into the hole left behind.
            wzct_pkg::ST_INS_RD: begin
                if (r_idx == '0) begin
                    mem_we  = 1'b1;
                    n_count = r_count + 1'b1;
                    n_state = wzct_pkg::ST_ACK;
                end else begin
                    mem_re      = 1'b1;
                    mem_rd_addr = AW'(r_idx - 1'b1);
                    n_state     = wzct_pkg::ST_INS_CHK;
                end
            end

            wzct_pkg::ST_INS_CHK: begin
                mem_we = 1'b1;
                if (r_rd_data.zstart > r_rs) begin
                    mem_wr_data = r_rd_data;
                    n_idx       = r_idx - 1'b1;
                    n_state     = wzct_pkg::ST_INS_RD;
                end else begin
                    n_count = r_count + 1'b1;
                    n_state = wzct_pkg::ST_ACK;
                end
            end

            // Remove compacts the table in place: entries that survive are copied down
            // to the write index, which never passes the read index.
            wzct_pkg::ST_REM_RD: begin
                if (r_idx == r_count) begin
                    n_count = r_wr;
                    n_state = wzct_pkg::ST_ACK;
                end else begin
                    mem_re  = 1'b1;
                    n_state = wzct_pkg::ST_REM_CHK;
                end
            end

            wzct_pkg::ST_REM_CHK: begin
                if (r_rd_data.region != r_region) begin
                    mem_we      = 1'b1;
                    mem_wr_addr = r_wr[AW-1:0];
                    mem_wr_data = r_rd_data;
                    n_wr        = r_wr + 1'b1;
                end
                n_idx   = r_idx + 1'b1;
                n_state = wzct_pkg::ST_REM_RD;
            end

            wzct_pkg::ST_EVL_RD: begin
                if (r_idx == r_count) begin
                    n_state = wzct_pkg::ST_EVL_END;
                end else begin
                    mem_re  = 1'b1;
                    n_state = wzct_pkg::ST_EVL_CHK;
                end
            end

            // Each crossing is held back one step, since only the next one (or the end
            // of the table) tells whether it is the final transfer.
            wzct_pkg::ST_EVL_CHK: begin
                if (was_in == now_in) begin
                    n_idx   = r_idx + 1'b1;
                    n_state = wzct_pkg::ST_EVL_RD;
                end else if (!r_pend_valid || can_push) begin
                    push          = r_pend_valid;
                    push_kind     = r_pend_kind;
                    push_region   = r_pend_region;
                    push_last     = 1'b0;
                    n_pend_valid  = 1'b1;
                    n_pend_kind   = now_in ? wzct_pkg::KIND_ENTER : wzct_pkg::KIND_EXIT;
                    n_pend_region = r_rd_data.region;
                    n_idx         = r_idx + 1'b1;
                    n_state       = wzct_pkg::ST_EVL_RD;
                end
            end

            wzct_pkg::ST_EVL_END: begin
                if (can_push) begin
                    push         = 1'b1;
                    n_pend_valid = 1'b0;
                    if (r_pend_valid) begin
                        push_kind   = r_pend_kind;
                        push_region = r_pend_region;
                    end
                    n_state = wzct_pkg::ST_IDLE;
                end
            end

            wzct_pkg::ST_ACK: begin
                if (can_push) begin
                    push        = 1'b1;
                    push_status = r_status;
                    n_state     = wzct_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = wzct_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_kind   = r_out_kind;
    assign o_event_region = r_out_region;
    assign o_status       = r_out_status;
    assign o_last         = r_out_last;

    `WZCT_NEVER(a_count_in_range, r_count > DEPTH_C, "zone count exceeds table depth")
    `WZCT_ASSERT(a_compact_order, (r_state == wzct_pkg::ST_REM_CHK) |-> (r_wr <= r_idx),
                 "remove write index passed read index")
    `WZCT_ASSERT(a_pend_in_eval, r_pend_valid |-> (r_state == wzct_pkg::ST_EVL_RD ||
                 r_state == wzct_pkg::ST_EVL_CHK || r_state == wzct_pkg::ST_EVL_END),
                 "held crossing outside evaluate")
    `WZCT_ASSERT(a_busy_after_accept, in_xfer |=> (r_state != wzct_pkg::ST_IDLE),
                 "command accepted but block stayed idle")
    `WZCT_ASSERT(a_write_below_depth, mem_we |-> (r_state == wzct_pkg::ST_REM_CHK ||
                 r_idx < DEPTH_C), "table write beyond depth")

endmodule

FILE: verif/tb_wraparound_zone_crossing_table.sv
module tb_wraparound_zone_crossing_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POS_ONE      = 1 << wzct_pkg::FRACTION_BITS_DEF;
    localparam int RANDOM_ITEMS = 200;
    localparam int SETTLE_TIME  = 64;
    localparam int DRAIN_LIMIT  = 20000;

    typedef struct packed {
        wzct_pkg::t_kind               kind;
        logic [wzct_pkg::REGION_W-1:0] region;
        wzct_pkg::t_status             status;
        logic                          last;
    } t_zone_event;

    typedef struct packed {
        wzct_pkg::t_op                 op;
        logic [wzct_pkg::REGION_W-1:0] region;
        logic [wzct_pkg::POS_W-1:0]    rs;
        logic [wzct_pkg::POS_W-1:0]    re;
        logic [wzct_pkg::POS_W-1:0]    ps;
        logic [wzct_pkg::POS_W-1:0]    pe;
        logic [wzct_pkg::POS_W-1:0]    cs;
        logic [wzct_pkg::POS_W-1:0]    ce;
        logic                          typed;
        wzct_pkg::t_status             want_status;
    } t_command_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic [1:0]                    i_operation = '0;
    logic [wzct_pkg::REGION_W-1:0] i_region_id = '0;
    logic [wzct_pkg::POS_W-1:0]    i_range_start = '0;
    logic [wzct_pkg::POS_W-1:0]    i_range_end = '0;
    logic [wzct_pkg::POS_W-1:0]    i_prev_start = '0;
    logic [wzct_pkg::POS_W-1:0]    i_prev_end = '0;
    logic [wzct_pkg::POS_W-1:0]    i_cur_start = '0;
    logic [wzct_pkg::POS_W-1:0]    i_cur_end = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic [1:0]                    o_event_kind;
    logic [wzct_pkg::REGION_W-1:0] o_event_region;
    logic [1:0]                    o_status;
    logic                          o_last;

    // Mirror of the zone table, kept in step with every accepted command.
    logic [wzct_pkg::POS_W-1:0]    zone_starts [wzct_pkg::TABLE_DEPTH_DEF];
    logic [wzct_pkg::POS_W-1:0]    zone_ends [wzct_pkg::TABLE_DEPTH_DEF];
    logic [wzct_pkg::REGION_W-1:0] zone_regions [wzct_pkg::TABLE_DEPTH_DEF];
    int                            zone_total = 0;

    t_zone_event  step_events [$];
    t_zone_event  pending_events [$];
    t_command_row directed_rows [$];
    int           mismatch_count = 0;
    bit           steady = 1'b0;

    wraparound_zone_crossing_table uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_region_id    (i_region_id),
        .i_range_start  (i_range_start),
        .i_range_end    (i_range_end),
        .i_prev_start   (i_prev_start),
        .i_prev_end     (i_prev_end),
        .i_cur_start    (i_cur_start),
        .i_cur_end      (i_cur_end),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_event_kind   (o_event_kind),
        .o_event_region (o_event_region),
        .o_status       (o_status),
        .o_last         (o_last)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // The span (s1,e1) and the zone (s2,e2) may each run past 1.0 and wrap to the origin.
    function automatic bit spans_overlap(int s1, int e1, int s2, int e2);
        if (s1 < e2) begin
            if (e1 >= s2)
                return 1'b1;
            return (e2 > POS_ONE) && (s1 <= e2 - POS_ONE);
        end
        return (e1 > POS_ONE) && (s2 <= e1 - POS_ONE);
    endfunction

    function automatic void predict_zone_events(t_command_row row);
        int          zs;
        int          ze;
        int          pend;
        int          cend;
        int          slot;
        int          k;
        int          kept;
        bit          was_in;
        bit          now_in;
        bit          have_held;
        t_zone_event ev;
        t_zone_event held;

        step_events.delete();
        ev.kind = wzct_pkg::KIND_ACK;
        ev.region = '0;
        ev.status = wzct_pkg::STATUS_OK;
        ev.last = 1'b1;
        held = ev;
        have_held = 1'b0;
        case (row.op)
            wzct_pkg::OP_INSERT: begin
                zs = int'(row.rs);
                ze = (row.re < row.rs) ? int'(row.rs) : int'(row.re);
                if (zs > POS_ONE || ze > 2 * POS_ONE) begin
                    ev.status = wzct_pkg::STATUS_INVALID;
                end else if (zone_total >= wzct_pkg::TABLE_DEPTH_DEF) begin
                    ev.status = wzct_pkg::STATUS_FULL;
                end else begin
                    // A new zone goes after every entry whose start is equal or lower.
                    slot = zone_total;
                    for (k = zone_total - 1; k >= 0; k--)
                        if (int'(zone_starts[k]) > zs)
                            slot = k;
                    for (k = zone_total; k > slot; k--) begin
                        zone_starts[k] = zone_starts[k-1];
                        zone_ends[k] = zone_ends[k-1];
                        zone_regions[k] = zone_regions[k-1];
                    end
                    zone_starts[slot] = zs[wzct_pkg::POS_W-1:0];
                    zone_ends[slot] = ze[wzct_pkg::POS_W-1:0];
                    zone_regions[slot] = row.region;
                    zone_total++;
                end
                step_events.push_back(ev);
            end
            wzct_pkg::OP_REMOVE: begin
                kept = 0;
                for (k = 0; k < zone_total; k++) begin
                    if (zone_regions[k] != row.region) begin
                        zone_starts[kept] = zone_starts[k];
                        zone_ends[kept] = zone_ends[k];
                        zone_regions[kept] = zone_regions[k];
                        kept++;
                    end
                end
                zone_total = kept;
                step_events.push_back(ev);
            end
            wzct_pkg::OP_EVALUATE: begin
                pend = (row.pe < row.ps) ? int'(row.ps) : int'(row.pe);
                cend = (row.ce < row.cs) ? int'(row.cs) : int'(row.ce);
                for (k = 0; k < zone_total; k++) begin
                    was_in = spans_overlap(int'(row.ps), pend, int'(zone_starts[k]),
                                           int'(zone_ends[k]));
                    now_in = spans_overlap(int'(row.cs), cend, int'(zone_starts[k]),
                                           int'(zone_ends[k]));
                    if (was_in != now_in) begin
                        if (have_held)
                            step_events.push_back(held);
                        held.kind = now_in ? wzct_pkg::KIND_ENTER : wzct_pkg::KIND_EXIT;
                        held.region = zone_regions[k];
                        held.status = wzct_pkg::STATUS_OK;
                        held.last = 1'b0;
                        have_held = 1'b1;
                    end
                end
                if (have_held) begin
                    held.last = 1'b1;
                    step_events.push_back(held);
                end else begin
                    step_events.push_back(ev);
                end
            end
            default: begin
                zone_total = 0;
                step_events.push_back(ev);
            end
        endcase
    endfunction

    task automatic add_row(wzct_pkg::t_op op, logic [wzct_pkg::REGION_W-1:0] region,
                           logic [wzct_pkg::POS_W-1:0] rs, logic [wzct_pkg::POS_W-1:0] re,
                           logic [wzct_pkg::POS_W-1:0] ps, logic [wzct_pkg::POS_W-1:0] pe,
                           logic [wzct_pkg::POS_W-1:0] cs, logic [wzct_pkg::POS_W-1:0] ce,
                           logic typed, wzct_pkg::t_status want_status);
        t_command_row row;

        row.op = op;
        row.region = region;
        row.rs = rs;
        row.re = re;
        row.ps = ps;
        row.pe = pe;
        row.cs = cs;
        row.ce = ce;
        row.typed = typed;
        row.want_status = want_status;
        directed_rows.push_back(row);
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic apply_command(t_command_row row);
        t_zone_event ev;

        i_in_valid <= 1'b1;
        i_operation <= row.op;
        i_region_id <= row.region;
        i_range_start <= row.rs;
        i_range_end <= row.re;
        i_prev_start <= row.ps;
        i_prev_end <= row.pe;
        i_cur_start <= row.cs;
        i_cur_end <= row.ce;
        do
            @(posedge i_clk);
        while (o_in_stall);
        predict_zone_events(row);
        if (row.typed) begin
            ev.kind = wzct_pkg::KIND_ACK;
            ev.region = '0;
            ev.status = row.want_status;
            ev.last = 1'b1;
            pending_events.push_back(ev);
        end else begin
            foreach (step_events[k])
                pending_events.push_back(step_events[k]);
        end
        @(negedge i_clk);
    endtask

    task automatic maybe_pause();
        int gap;

        if (!steady && $urandom_range(0, 99) < 31) begin
            gap = $urandom_range(1, 4);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic drain_pending();
        i_in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        i_out_stall <= !steady && ($urandom_range(0, 99) < 31);
    end

    always @(posedge i_clk) begin : result_check
        t_zone_event want;

        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_events.size() == 0) begin
                $error("unexpected result: event_kind %0d event_region %0d status %0d last %0d",
                       o_event_kind, o_event_region, o_status, o_last);
                mismatch_count++;
            end else begin
                want = pending_events.pop_front();
                if (o_event_kind !== want.kind) begin
                    $error("event_kind: expected %0d, got %0d", want.kind, o_event_kind);
                    mismatch_count++;
                end
                if (o_event_region !== want.region) begin
                    $error("event_region: expected %0d, got %0d", want.region, o_event_region);
                    mismatch_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatch_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : stimulus
        t_command_row  row;
        int            n;
        int            roll;
        int            track_pos;
        int            waited;
        wzct_pkg::t_op op;

        track_pos = 0;

        add_row(wzct_pkg::OP_EVALUATE, 8'h00, 0, 0, 0, 100, 200, 300, 1'b1,
                wzct_pkg::STATUS_OK);
        add_row(wzct_pkg::OP_REMOVE, 8'hFF, 0, 0, 0, 0, 0, 0, 1'b1, wzct_pkg::STATUS_OK);
        add_row(wzct_pkg::OP_CLEAR, 8'h00, 0, 0, 0, 0, 0, 0, 1'b1, wzct_pkg::STATUS_OK);
        add_row(wzct_pkg::OP_INSERT, 8'h01, 16'd32769, 16'd40000, 0, 0, 0, 0, 1'b1,
                wzct_pkg::STATUS_INVALID);
        add_row(wzct_pkg::OP_INSERT, 8'hFF, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 1'b1,
                wzct_pkg::STATUS_INVALID);
        add_row(wzct_pkg::OP_INSERT, 8'h00, 0, 0, 0, 0, 0, 0, 1'b1, wzct_pkg::STATUS_OK);
        add_row(wzct_pkg::OP_INSERT, 8'hFF, 16'd32768, 16'hFFFF, 0, 0, 0, 0, 1'b1,
                wzct_pkg::STATUS_OK);
        // Reversed zone: the end is raised to the start.
        add_row(wzct_pkg::OP_INSERT, 8'h11, 16'd1000, 16'd10, 0, 0, 0, 0, 1'b1,
                wzct_pkg::STATUS_OK);
        add_row(wzct_pkg::OP_INSERT, 8'h22, 16'd1000, 16'd2000, 0, 0, 0, 0, 1'b1,
                wzct_pkg::STATUS_OK);
        add_row(wzct_pkg::OP_INSERT, 8'h33, 16'd30000, 16'd40000, 0, 0, 0, 0, 1'b1,
                wzct_pkg::STATUS_OK);
        add_row(wzct_pkg::OP_INSERT, 8'h44, 0, 16'hFFFF, 0, 0, 0, 0, 1'b1,
                wzct_pkg::STATUS_OK);
        add_row(wzct_pkg::OP_EVALUATE, 8'h00, 0, 0, 0, 0, 16'd1000, 16'd1500,
                1'b0, wzct_pkg::STATUS_OK);
        add_row(wzct_pkg::OP_EVALUATE, 8'h00, 0, 0, 16'd1000, 16'd1500, 16'd5000, 16'd100,
                1'b0, wzct_pkg::STATUS_OK);
        add_row(wzct_pkg::OP_EVALUATE, 8'h00, 0, 0, 16'd5000, 16'd5000, 16'd32000,
                16'd34000, 1'b0, wzct_pkg::STATUS_OK);
        add_row(wzct_pkg::OP_EVALUATE, 8'h00, 0, 0, 16'd32000, 16'd34000, 16'd100,
                16'd200, 1'b0, wzct_pkg::STATUS_OK);
        add_row(wzct_pkg::OP_EVALUATE, 8'h00, 0, 0, 16'hFFFF, 16'hFFFF, 0, 16'hFFFF,
                1'b0, wzct_pkg::STATUS_OK);
        add_row(wzct_pkg::OP_EVALUATE, 8'h00, 0, 0, 0, 16'hFFFF, 16'hFFFF, 0,
                1'b0, wzct_pkg::STATUS_OK);
        add_row(wzct_pkg::OP_REMOVE, 8'h22, 0, 0, 0, 0, 0, 0, 1'b1, wzct_pkg::STATUS_OK);
        add_row(wzct_pkg::OP_REMOVE, 8'h99, 0, 0, 0, 0, 0, 0, 1'b1, wzct_pkg::STATUS_OK);
        add_row(wzct_pkg::OP_EVALUATE, 8'h00, 0, 0, 16'd20000, 16'd20000, 16'd1500,
                16'd1500, 1'b0, wzct_pkg::STATUS_OK);
        add_row(wzct_pkg::OP_CLEAR, 8'h00, 0, 0, 0, 0, 0, 0, 1'b1, wzct_pkg::STATUS_OK);
        add_row(wzct_pkg::OP_EVALUATE, 8'h00, 0, 0, 0, 16'd1000, 16'd30000, 16'd40000,
                1'b1, wzct_pkg::STATUS_OK);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[k]) begin
            maybe_pause();
            apply_command(directed_rows[k]);
        end
        drain_pending();

        // The first stretch is mostly inserts so that the table fills and overflows;
        // later the mix turns to evaluates, removes and the odd clear.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= 100 && n < 140);
            if (n == 60)
                drain_pending();
            roll = $urandom_range(0, 99);
            if (n < 80)
                op = (roll < 70) ? wzct_pkg::OP_INSERT :
                     (roll < 98) ? wzct_pkg::OP_EVALUATE : wzct_pkg::OP_REMOVE;
            else
                op = (roll < 20) ? wzct_pkg::OP_INSERT :
                     (roll < 85) ? wzct_pkg::OP_EVALUATE :
                     (roll < 97) ? wzct_pkg::OP_REMOVE : wzct_pkg::OP_CLEAR;
            row.op = op;
            row.region = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                     : 8'($urandom_range(0, 7));
            row.typed = 1'b0;
            row.want_status = wzct_pkg::STATUS_OK;
            if ($urandom_range(0, 9) == 0) begin
                row.rs = 16'($urandom_range(0, 16'hFFFF));
                row.re = 16'($urandom_range(0, 16'hFFFF));
                row.ps = 16'($urandom_range(0, 16'hFFFF));
                row.pe = 16'($urandom_range(0, 16'hFFFF));
                row.cs = 16'($urandom_range(0, 16'hFFFF));
                row.ce = 16'($urandom_range(0, 16'hFFFF));
            end else begin
                row.rs = 16'($urandom_range(0, POS_ONE));
                row.re = 16'(int'(row.rs) + $urandom_range(0, 12000));
                row.ps = 16'(track_pos);
                row.pe = 16'(track_pos + $urandom_range(0, 2000));
                roll = track_pos + $urandom_range(0, 4000);
                if (roll > POS_ONE)
                    roll -= POS_ONE;
                row.cs = 16'(roll);
                row.ce = 16'(roll + $urandom_range(0, 2000));
                if (op == wzct_pkg::OP_EVALUATE)
                    track_pos = roll;
            end
            maybe_pause();
            apply_command(row);
        end
        steady = 1'b0;
        i_in_valid <= 1'b0;

        waited = 0;
        while (pending_events.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (SETTLE_TIME) @(negedge i_clk);
        if (pending_events.size() != 0) begin
            $error("%0d expected results never arrived", pending_events.size());
            mismatch_count++;
        end

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
